[sv/er_pkg.sv]
`timescale 1ns / 1ps
// er_pkg: shared types, kind codes and register indexes for the rotor core.
// Used by er_wiring, enigma_rotor_core and er_checker.
package er_pkg;

	localparam int ALPHABET_DEF = 26;
	localparam int LETTER_W     = 5;
	localparam int KIND_W       = 3;
	localparam int NOTCH_W      = 26;
	localparam int CFG_IDX_W    = 1;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FWD   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BWD   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STEP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_START = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 1'd1;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] wiring_value;
		logic                step_enable;
	} req_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_out;
		logic                notch_at_top;
		logic [LETTER_W-1:0] position_out;
	} rsp_t;

	// wiring write from the core to the wiring store
	typedef struct packed {
		logic                en;
		logic [LETTER_W-1:0] idx;
		logic [LETTER_W-1:0] val;
	} load_t;

endpackage

[sv/er_wiring.sv]
`timescale 1ns / 1ps
// er_wiring: rotor wiring store with the forward and inverse lookups.
// Depends on er_pkg.
module er_wiring #(
	parameter int ALPHABET = er_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  er_pkg::load_t                 ld,
	input  logic [er_pkg::LETTER_W-1:0]   letter,
	input  logic [$clog2(ALPHABET)-1:0]   position,
	output logic [er_pkg::LETTER_W-1:0]   fwd_letter,
	output logic [er_pkg::LETTER_W-1:0]   bwd_letter
);
	localparam int PW  = $clog2(ALPHABET);
	localparam int LW  = er_pkg::LETTER_W;
	localparam int NV  = 2 ** LW;
	localparam int SW  = PW + LW + 1;
	localparam logic [PW:0]   A_P1 = (PW + 1)'(ALPHABET);
	localparam logic [SW-1:0] A_SW = SW'(ALPHABET);

	logic [PW-1:0] wir_q [ALPHABET];
	logic [ALPHABET-1:0] written_q;
	logic [PW-1:0] mod_tbl [NV];

	logic                loaded;
	logic [PW+LW-1:0]    ld_idx_x;
	logic [PW-1:0]       lmod;
	logic [PW:0]         isum;
	logic [PW-1:0]       fidx;
	logic [PW-1:0]       fw;
	logic [PW:0]         fdiff;
	logic [PW+LW:0]      fdiff_x;
	logic [SW-1:0]       tsum;
	logic [SW-1:0]       tsum_w;
	logic [PW-1:0]       target;
	logic [ALPHABET-1:0] match;
	logic [2*ALPHABET-1:0] rot;
	logic [ALPHABET-1:0] cand;
	logic [PW-1:0]       first_c;
	logic [PW+LW-1:0]    first_x;

	// constant table: value mod alphabet size for every 5-bit code
	for (genvar i = 0; i < NV; i++) begin : g_mod
		assign mod_tbl[i] = PW'(i % ALPHABET);
	end

	assign ld_idx_x = {{PW{1'b0}}, ld.idx};
	assign loaded   = &written_q;

	// wiring entries, stored already reduced mod the alphabet
	always_ff @(posedge clk) begin
		if (ld.en && (ld.idx < ALPHABET)) begin
			wir_q[ld_idx_x[PW-1:0]] <= mod_tbl[ld.val];
		end
	end

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ld.en && (ld.idx < ALPHABET)) begin
			written_q[ld_idx_x[PW-1:0]] <= 1'b1;
		end
	end

	// forward: contact at (c+p) mod A, then back off by p
	always_comb begin
		lmod    = mod_tbl[letter];
		isum    = {1'b0, lmod} + {1'b0, position};
		fidx    = (isum >= A_P1) ? PW'(isum - A_P1) : isum[PW-1:0];
		fw      = wir_q[fidx];
		fdiff   = (fw >= position) ? ({1'b0, fw} - {1'b0, position})
		                           : ({1'b0, fw} + A_P1 - {1'b0, position});
		fdiff_x = {{LW{1'b0}}, fdiff};
		fwd_letter = loaded ? fdiff_x[LW-1:0] : letter;
	end

	// inverse: entries holding (L+p) mod A, rotated by p, lowest wins
	always_comb begin
		tsum   = SW'(letter) + SW'(position);
		tsum_w = (tsum >= A_SW) ? (tsum - A_SW) : tsum;
		target = tsum_w[PW-1:0];
		for (int j = 0; j < ALPHABET; j++) begin
			match[j] = (wir_q[j] == target);
		end
		rot  = {match, match} >> position;
		cand = rot[ALPHABET-1:0];
		first_c = '0;
		for (int c = ALPHABET - 1; c >= 0; c--) begin
			if (cand[c]) begin
				first_c = PW'(c);
			end
		end
		first_x = {{LW{1'b0}}, first_c};
		if (!loaded) begin
			bwd_letter = letter;
		end else if (letter < ALPHABET) begin
			bwd_letter = first_x[LW-1:0];
		end else begin
			bwd_letter = '0;
		end
	end

endmodule

[sv/enigma_rotor_core.sv]
`timescale 1ns / 1ps
// enigma_rotor_core: top level of the single-rotor cipher block.
// Depends on er_pkg and er_wiring.
//
// Usage:
//  - req channel (req_valid/req_ready/req) takes one request per cycle:
//    load a wiring entry, map a letter forward or backward, step the
//    rotor, or return it to the configured start position.
//  - rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response
//    per request, in order: mapped letter (zero for non-map kinds), the
//    position after the request and the notch flag at that position.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the notch
//    mask (index 0) or start position (index 1); always ready, and meant
//    to be used only while no request is in flight.
//  - A request passes through an input register, then one pass of lookup
//    logic into the response register.
//  - Throughput is one request per cycle while rsp_ready is high; the wiring
//    lookup (parallel compare over all entries for the inverse map) is combinational.
//  - When rsp_ready is low the response register holds; the input register
//    takes one more request only if empty, and req_ready is low while full.
//  - Reset clears position, written flags and config; wiring entries are
//    unknown until loaded, and maps pass letters through until all are.
module enigma_rotor_core #(
	parameter int ALPHABET = er_pkg::ALPHABET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  er_pkg::req_t                   req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output er_pkg::rsp_t                   rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [er_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [er_pkg::NOTCH_W-1:0]     cfg_data
);
	localparam int PW = $clog2(ALPHABET);
	localparam int LW = er_pkg::LETTER_W;
	localparam logic [PW-1:0] LAST_POS = PW'(ALPHABET - 1);

	er_pkg::req_t   req_s1;
	logic           vld_s1;
	er_pkg::rsp_t   rsp_q;
	logic           rsp_vld_q;
	logic [PW-1:0]  pos_q;
	logic [er_pkg::NOTCH_W-1:0] notch_q;
	logic [LW-1:0]  start_q;

	logic           adv;
	er_pkg::load_t  ld;
	logic [LW-1:0]  fwd_letter;
	logic [LW-1:0]  bwd_letter;
	logic [PW-1:0]  pos_nx;
	logic [LW-1:0]  letter_nx;
	logic [PW+LW-1:0] start_x;
	logic [PW+LW-1:0] pos_x;
	logic           notch_nx;

	assign adv       = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || adv;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notch_q <= '0;
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				er_pkg::CFG_NOTCH_MASK: notch_q <= cfg_data;
				er_pkg::CFG_START_POS:  start_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// wiring load request
	always_comb begin
		ld.en  = adv && (req_s1.kind == er_pkg::KIND_LOAD);
		ld.idx = req_s1.letter;
		ld.val = req_s1.wiring_value;
	end

	er_wiring #(
		.ALPHABET (ALPHABET)
	) u_wiring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.letter     (req_s1.letter),
		.position   (pos_q),
		.fwd_letter (fwd_letter),
		.bwd_letter (bwd_letter)
	);

	// next position and mapped letter
	always_comb begin
		start_x   = {{PW{1'b0}}, start_q};
		pos_nx    = pos_q;
		letter_nx = '0;
		case (req_s1.kind)
			er_pkg::KIND_FWD: letter_nx = fwd_letter;
			er_pkg::KIND_BWD: letter_nx = bwd_letter;
			er_pkg::KIND_STEP: begin
				if (req_s1.step_enable) begin
					pos_nx = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
				end
			end
			er_pkg::KIND_START: begin
				if (start_q < ALPHABET) begin
					pos_nx = start_x[PW-1:0];
				end
			end
			default: ;
		endcase
		pos_x    = {{LW{1'b0}}, pos_nx};
		notch_nx = 1'b0;
		if (pos_nx < er_pkg::NOTCH_W) begin
			notch_nx = notch_q[pos_x[LW-1:0]];
		end
	end

	// rotor position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv) begin
			pos_q <= pos_nx;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.letter_out   <= letter_nx;
			rsp_q.notch_at_top <= notch_nx;
			rsp_q.position_out <= pos_x[LW-1:0];
		end
	end

endmodule

[sv/er_checker.sv]
`timescale 1ns / 1ps
// er_checker: port-level assertions for enigma_rotor_core, bound to it below.
// Depends on er_pkg.
module er_checker #(
	parameter int ALPHABET = er_pkg::ALPHABET_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         req_ready,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input er_pkg::rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// with the output empty the input side never blocks
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty output");

	// reported position stays inside the alphabet
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (ALPHABET > 32) || (rsp.position_out < ALPHABET))
		else $error("position out of range");

	// no notch beyond the mask
	a_notch_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.position_out >= er_pkg::NOTCH_W) |-> !rsp.notch_at_top)
		else $error("notch reported beyond mask");

endmodule

bind enigma_rotor_core er_checker #(
	.ALPHABET (ALPHABET)
) u_er_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
